// ----- design/bec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event collector package
// Shared types and codes for the button event collector modules.
// ----------------------------------------------------------------------------
package bec_pkg;

    // Number of buttons and the width of the held-flags word.
    localparam int BUTTON_COUNT = 5;
    localparam int TIME_W       = 32;
    localparam int CODE_W       = 8;
    localparam int ACTION_W     = 2;

    // Item actions.
    localparam logic [ACTION_W-1:0] ACT_FRAME_BEGIN = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_EVENT       = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FRAME_END   = 2'd2;

    // Event states.
    localparam logic [CODE_W-1:0] STATE_RELEASED = 8'd1;
    localparam logic [CODE_W-1:0] STATE_PRESSED  = 8'd2;

    // Event types.
    localparam logic [CODE_W-1:0] TYPE_MENU     = 8'd1;
    localparam logic [CODE_W-1:0] TYPE_SELECT   = 8'd2;
    localparam logic [CODE_W-1:0] TYPE_PREVIOUS = 8'd3;
    localparam logic [CODE_W-1:0] TYPE_PLAY     = 8'd4;
    localparam logic [CODE_W-1:0] TYPE_NEXT     = 8'd5;

    // Button bits in the held-flags word.
    localparam logic [BUTTON_COUNT-1:0] BTN_SELECT   = 5'b00001;
    localparam logic [BUTTON_COUNT-1:0] BTN_PREVIOUS = 5'b00010;
    localparam logic [BUTTON_COUNT-1:0] BTN_PLAY     = 5'b00100;
    localparam logic [BUTTON_COUNT-1:0] BTN_NEXT     = 5'b01000;
    localparam logic [BUTTON_COUNT-1:0] BTN_MENU     = 5'b10000;
    localparam logic [BUTTON_COUNT-1:0] BTN_NONE     = 5'b00000;

    // One input request.
    typedef struct packed {
        logic [ACTION_W-1:0]     action;
        logic [BUTTON_COUNT-1:0] flags_in;
        logic [TIME_W-1:0]       frame_time;
        logic [CODE_W-1:0]       btn_code;
        logic [CODE_W-1:0]       event_state;
    } t_item;

    // One result.
    typedef struct packed {
        logic [BUTTON_COUNT-1:0] flags_out;
        logic                    hand_back;
        logic [TIME_W-1:0]       next_time;
        logic [TIME_W-1:0]       menu_time;
    } t_result;

endpackage

// ----- design/bec_fold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event fold
// Holds the frame state and folds one request into it per cycle in which i_fire is high.
// ----------------------------------------------------------------------------
module bec_fold (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  bec_pkg::t_item                   i_item,
    input  logic [bec_pkg::BUTTON_COUNT-1:0] i_release_mask,
    output bec_pkg::t_result                 o_result
);
    import bec_pkg::*;

    logic [BUTTON_COUNT-1:0] r_held;
    logic [BUTTON_COUNT-1:0] r_entry;
    logic [BUTTON_COUNT-1:0] r_deferred;
    logic [BUTTON_COUNT-1:0] r_touched;
    logic [TIME_W-1:0]       r_cur_time;
    logic [TIME_W-1:0]       r_next_stamp;
    logic [TIME_W-1:0]       r_menu_stamp;

    logic [BUTTON_COUNT-1:0] n_held;
    logic [BUTTON_COUNT-1:0] n_entry;
    logic [BUTTON_COUNT-1:0] n_deferred;
    logic [BUTTON_COUNT-1:0] n_touched;
    logic [TIME_W-1:0]       n_cur_time;
    logic [TIME_W-1:0]       n_next_stamp;
    logic [TIME_W-1:0]       n_menu_stamp;
    logic                    w_hand;
    logic [BUTTON_COUNT-1:0] w_bit;
    logic [BUTTON_COUNT-1:0] w_flip;
    logic                    w_known_state;

    // Map the event type onto its button bit; unknown types name no button.
    always_comb begin
        case (i_item.btn_code)
            TYPE_MENU:     w_bit = BTN_MENU;
            TYPE_SELECT:   w_bit = BTN_SELECT;
            TYPE_PREVIOUS: w_bit = BTN_PREVIOUS;
            TYPE_PLAY:     w_bit = BTN_PLAY;
            TYPE_NEXT:     w_bit = BTN_NEXT;
            default:       w_bit = BTN_NONE;
        endcase
    end

    assign w_known_state = (i_item.event_state == STATE_PRESSED) ||
                           (i_item.event_state == STATE_RELEASED);

    // Touched buttons that ended the frame where they began get flipped.
    assign w_flip = r_touched & ~(r_held ^ r_entry);

    // Next-state fold for one request.
    always_comb begin
        n_held       = r_held;
        n_entry      = r_entry;
        n_deferred   = r_deferred;
        n_touched    = r_touched;
        n_cur_time   = r_cur_time;
        n_next_stamp = r_next_stamp;
        n_menu_stamp = r_menu_stamp;
        w_hand       = 1'b0;
        case (i_item.action)
            ACT_FRAME_BEGIN: begin
                n_entry    = i_item.flags_in;
                n_held     = i_item.flags_in ^ r_deferred;
                n_deferred = '0;
                n_touched  = '0;
                n_cur_time = i_item.frame_time;
            end
            ACT_EVENT: begin
                if (i_item.event_state == STATE_PRESSED) begin
                    if (w_bit == BTN_NEXT) begin
                        n_next_stamp = r_cur_time;
                    end
                    if (w_bit == BTN_MENU) begin
                        n_menu_stamp = r_cur_time;
                    end
                    n_held = r_held | w_bit;
                end else if (i_item.event_state == STATE_RELEASED) begin
                    n_held = r_held & ~w_bit;
                end
                if (w_known_state) begin
                    w_hand    = (w_bit != BTN_MENU) && ((i_release_mask & w_bit) != '0);
                    n_touched = r_touched | w_bit;
                end
            end
            ACT_FRAME_END: begin
                n_held     = r_held ^ w_flip;
                n_deferred = r_deferred | w_flip;
                n_touched  = '0;
            end
            default: begin
                // Unused action: state stands and is reported as is.
            end
        endcase
    end

    // Frame state registers, updated only when a request is processed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_entry      <= '0;
            r_deferred   <= '0;
            r_touched    <= '0;
            r_cur_time   <= '0;
            r_next_stamp <= '0;
            r_menu_stamp <= '0;
        end else if (i_fire) begin
            r_held       <= n_held;
            r_entry      <= n_entry;
            r_deferred   <= n_deferred;
            r_touched    <= n_touched;
            r_cur_time   <= n_cur_time;
            r_next_stamp <= n_next_stamp;
            r_menu_stamp <= n_menu_stamp;
        end
    end

    // The result reflects the state after this request.
    assign o_result.flags_out = n_held;
    assign o_result.hand_back = w_hand;
    assign o_result.next_time = n_next_stamp;
    assign o_result.menu_time = n_menu_stamp;

endmodule

// ----- design/button_event_collector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event collector
// Folds per-frame button press and release events into a held-flags word.
// ----------------------------------------------------------------------------
// Each request (frame begin, button event or frame end) gives exactly one
// result. Requests are taken into an input register and folded into the frame
// state on their way to the result register, so the block sustains one
// request per clock while the result channel does not stall. A result becomes
// valid in the result register once its request advances out of the input
// register. The result register and the input register each hold one request,
// so one request is still taken into an empty input register while a finished
// result waits. The release mask is written through its own port, which is
// always ready, and should be changed only while no request is in flight.
module button_event_collector (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input request channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bec_pkg::ACTION_W-1:0]     i_action,
    input  logic [bec_pkg::BUTTON_COUNT-1:0] i_flags_in,
    input  logic [bec_pkg::TIME_W-1:0]       i_frame_time,
    input  logic [bec_pkg::CODE_W-1:0]       i_btn_code,
    input  logic [bec_pkg::CODE_W-1:0]       i_event_state,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [bec_pkg::BUTTON_COUNT-1:0] o_flags_out,
    output logic                             o_hand_back,
    output logic [bec_pkg::TIME_W-1:0]       o_next_time,
    output logic [bec_pkg::TIME_W-1:0]       o_menu_time,
    // Release mask write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bec_pkg::BUTTON_COUNT-1:0] i_cfg_release_mask
);
    import bec_pkg::*;

    logic                    r_in_valid;
    t_item                   r_item;
    logic                    r_out_valid;
    t_result                 r_result;
    logic [BUTTON_COUNT-1:0] r_release_mask;
    t_result                 w_result;
    logic                    w_advance;
    logic                    w_in_accept;

    // The input register moves on whenever the result register is free.
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item.action      <= i_action;
            r_item.flags_in    <= i_flags_in;
            r_item.frame_time  <= i_frame_time;
            r_item.btn_code    <= i_btn_code;
            r_item.event_state <= i_event_state;
        end
    end

    // Release mask register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_release_mask <= i_cfg_release_mask;
        end
    end

    bec_fold u_fold (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_advance),
        .i_item         (r_item),
        .i_release_mask (r_release_mask),
        .o_result       (w_result)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_flags_out = r_result.flags_out;
    assign o_hand_back = r_result.hand_back;
    assign o_next_time = r_result.next_time;
    assign o_menu_time = r_result.menu_time;

endmodule

// ----- design/bec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event collector checker
// Port-level checks on the collector, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bec_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic                             o_hand_back,
    input logic                             i_cfg_valid,
    input logic                             o_cfg_ready,
    input logic [bec_pkg::BUTTON_COUNT-1:0] i_cfg_release_mask
);
    import bec_pkg::*;

    logic [BUTTON_COUNT-1:0] r_mask_copy;

    // Shadow of the release mask as seen on the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_copy <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask_copy <= i_cfg_release_mask;
        end
    end

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    // An empty result register never back-pressures the input.
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // An accepted request, not stalled on its way out of the input register, reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 !i_out_stall |=> o_out_valid)
        else $error("accepted request did not produce a result");

    // A hand-back can only come from a button in the release mask.
    a_hand_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hand_back) |-> (r_mask_copy != '0))
        else $error("hand-back with empty release mask");

endmodule

bind button_event_collector bec_checker u_bec_checker (.*);

// ----- verif/button_event_collector_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event collector testbench
// Drives frame-begin, button-event and frame-end requests into the collector
// under random input gaps and result stalls. A local model of the held-flags
// word, the deferred flip-backs and the press stamps predicts every result,
// and each result is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module button_event_collector_test;
    import bec_pkg::*;

    // Codes that the package leaves unnamed.
    localparam logic [ACTION_W-1:0] ACT_UNUSED    = 2'd3;
    localparam logic [CODE_W-1:0]   TYPE_NONE     = 8'd0;
    localparam logic [CODE_W-1:0]   TYPE_AFTER    = 8'd6;
    localparam logic [CODE_W-1:0]   CODE_MAX      = 8'hFF;
    localparam logic [CODE_W-1:0]   STATE_IDLE    = 8'd0;
    localparam logic [CODE_W-1:0]   STATE_OTHER   = 8'd3;
    localparam logic [BUTTON_COUNT-1:0] BTN_ALL   = 5'b11111;
    localparam logic [TIME_W-1:0]   TIME_MAX      = 32'hFFFF_FFFF;

    localparam int QUIET_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 4;
    localparam int PRINT_LIMIT  = 50;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [ACTION_W-1:0]     i_action = ACT_FRAME_BEGIN;
    logic [BUTTON_COUNT-1:0] i_flags_in = BTN_NONE;
    logic [TIME_W-1:0]       i_frame_time = '0;
    logic [CODE_W-1:0]       i_btn_code = TYPE_NONE;
    logic [CODE_W-1:0]       i_event_state = STATE_IDLE;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [BUTTON_COUNT-1:0] o_flags_out;
    logic                    o_hand_back;
    logic [TIME_W-1:0]       o_next_time;
    logic [TIME_W-1:0]       o_menu_time;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [BUTTON_COUNT-1:0] i_cfg_release_mask = BTN_NONE;

    // Predicted frame state.
    logic [BUTTON_COUNT-1:0] held_word = BTN_NONE;
    logic [BUTTON_COUNT-1:0] entry_word = BTN_NONE;
    logic [BUTTON_COUNT-1:0] flip_back = BTN_NONE;
    logic [BUTTON_COUNT-1:0] touched_word = BTN_NONE;
    logic [TIME_W-1:0]       frame_clock = '0;
    logic [TIME_W-1:0]       next_stamp = '0;
    logic [TIME_W-1:0]       menu_stamp = '0;
    logic [BUTTON_COUNT-1:0] handback_mask = BTN_NONE;

    t_result expected_results[$];
    int      error_count = 0;
    bit      idling_on = 1'b1;
    int      stall_left = 0;

    button_event_collector i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_flags_in         (i_flags_in),
        .i_frame_time       (i_frame_time),
        .i_btn_code         (i_btn_code),
        .i_event_state      (i_event_state),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_flags_out        (o_flags_out),
        .o_hand_back        (o_hand_back),
        .o_next_time        (o_next_time),
        .o_menu_time        (o_menu_time),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_release_mask (i_cfg_release_mask)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Maps an event type code to its bit in the held word.
    function automatic logic [BUTTON_COUNT-1:0] button_of(input logic [CODE_W-1:0] code);
        case (code)
            TYPE_MENU:     return BTN_MENU;
            TYPE_SELECT:   return BTN_SELECT;
            TYPE_PREVIOUS: return BTN_PREVIOUS;
            TYPE_PLAY:     return BTN_PLAY;
            TYPE_NEXT:     return BTN_NEXT;
            default:       return BTN_NONE;
        endcase
    endfunction

    // Applies one request to the predicted frame state and returns its result.
    function automatic t_result fold_request(input t_item req);
        logic [BUTTON_COUNT-1:0] btn;
        logic [BUTTON_COUNT-1:0] flips;
        t_result                 res;
        res.hand_back = 1'b0;
        case (req.action)
            ACT_FRAME_BEGIN: begin
                entry_word   = req.flags_in;
                held_word    = req.flags_in ^ flip_back;
                flip_back    = BTN_NONE;
                touched_word = BTN_NONE;
                frame_clock  = req.frame_time;
            end
            ACT_EVENT: begin
                btn = button_of(req.btn_code);
                if (req.event_state == STATE_PRESSED) begin
                    if (btn == BTN_NEXT) begin
                        next_stamp = frame_clock;
                    end else if (btn == BTN_MENU) begin
                        menu_stamp = frame_clock;
                    end
                    held_word = held_word | btn;
                end else if (req.event_state == STATE_RELEASED) begin
                    held_word = held_word & ~btn;
                end
                if (req.event_state == STATE_PRESSED ||
                    req.event_state == STATE_RELEASED) begin
                    res.hand_back = (btn != BTN_MENU) && ((handback_mask & btn) != BTN_NONE);
                    touched_word  = touched_word | btn;
                end
            end
            ACT_FRAME_END: begin
                // A touched button that ended where it began gets a one-frame flip.
                flips        = touched_word & ~(held_word ^ entry_word);
                flip_back    = flip_back | flips;
                held_word    = held_word ^ flips;
                touched_word = BTN_NONE;
            end
            default: begin
            end
        endcase
        res.flags_out = held_word;
        res.next_time = next_stamp;
        res.menu_time = menu_stamp;
        return res;
    endfunction

    function automatic t_item make_item(input logic [ACTION_W-1:0] act,
                                        input logic [BUTTON_COUNT-1:0] flags,
                                        input logic [TIME_W-1:0] stamp,
                                        input logic [CODE_W-1:0] code,
                                        input logic [CODE_W-1:0] state);
        t_item req;
        req.action      = act;
        req.flags_in    = flags;
        req.frame_time  = stamp;
        req.btn_code    = code;
        req.event_state = state;
        return req;
    endfunction

    function automatic logic [BUTTON_COUNT-1:0] rand_flags();
        logic [31:0] r;
        r = $urandom;
        return r[BUTTON_COUNT-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] rand_code();
        logic [31:0] r;
        r = $urandom;
        return r[CODE_W-1:0];
    endfunction

    function automatic logic [CODE_W-1:0] button_code();
        logic [31:0] r;
        r = $urandom_range(1, 5);
        return r[CODE_W-1:0];
    endfunction

    // Mostly real buttons, now and then any code at all.
    function automatic logic [CODE_W-1:0] pick_type();
        if ($urandom_range(0, 7) == 0) begin
            return rand_code();
        end
        return button_code();
    endfunction

    function automatic logic [CODE_W-1:0] pick_state();
        if ($urandom_range(0, 7) == 0) begin
            return rand_code();
        end
        return ($urandom_range(0, 1) == 0) ? STATE_PRESSED : STATE_RELEASED;
    endfunction

    // Fields that an event ignores are filled with random values.
    function automatic t_item make_event(input logic [CODE_W-1:0] code,
                                         input logic [CODE_W-1:0] state);
        return make_item(ACT_EVENT, rand_flags(), $urandom, code, state);
    endfunction

    function automatic t_item make_frame(input logic [ACTION_W-1:0] act);
        return make_item(act, rand_flags(), $urandom, rand_code(), rand_code());
    endfunction

    function automatic t_item random_item();
        logic [31:0] r;
        r = $urandom;
        return make_item(r[ACTION_W-1:0], rand_flags(), $urandom, rand_code(), rand_code());
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
        end
        error_count++;
    endtask

    // Sends one request, with an occasional gap before it, and records its result.
    task automatic send_request(input t_item req);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 5);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= req.action;
        i_flags_in    <= req.flags_in;
        i_frame_time  <= req.frame_time;
        i_btn_code    <= req.btn_code;
        i_event_state <= req.event_state;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(fold_request(req));
    endtask

    task automatic stop_requests();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // The mask is only changed with nothing in flight.
    task automatic set_release_mask(input logic [BUTTON_COUNT-1:0] mask);
        wait_for_results();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        i_cfg_valid        <= 1'b1;
        i_cfg_release_mask <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        handback_mask = mask;
    endtask

    // Events, a frame end and an unused action straight after reset, before any frame begins.
    task automatic test_outside_frame();
        send_request(make_event(TYPE_NEXT, STATE_PRESSED));
        send_request(make_event(TYPE_SELECT, STATE_RELEASED));
        send_request(make_frame(ACT_FRAME_END));
        send_request(make_frame(ACT_UNUSED));
        stop_requests();
    endtask

    // Every button, every state, unknown codes and both one-frame cases.
    task automatic test_directed_frames();
        set_release_mask(BTN_ALL);
        send_request(make_item(ACT_FRAME_BEGIN, BTN_ALL, TIME_MAX, CODE_MAX, CODE_MAX));
        send_request(make_event(TYPE_MENU, STATE_PRESSED));
        send_request(make_event(TYPE_SELECT, STATE_PRESSED));
        send_request(make_event(TYPE_PREVIOUS, STATE_PRESSED));
        send_request(make_event(TYPE_PLAY, STATE_PRESSED));
        send_request(make_event(TYPE_NEXT, STATE_PRESSED));
        send_request(make_event(TYPE_SELECT, STATE_RELEASED));
        send_request(make_event(TYPE_SELECT, STATE_PRESSED));
        send_request(make_event(TYPE_NONE, STATE_PRESSED));
        send_request(make_event(CODE_MAX, STATE_RELEASED));
        send_request(make_event(TYPE_AFTER, STATE_PRESSED));
        send_request(make_event(TYPE_SELECT, STATE_IDLE));
        send_request(make_event(TYPE_PREVIOUS, CODE_MAX));
        send_request(make_event(TYPE_NEXT, STATE_OTHER));
        send_request(make_frame(ACT_FRAME_END));
        send_request(make_item(ACT_FRAME_BEGIN, BTN_NONE, '0, TYPE_NONE, STATE_IDLE));
        send_request(make_event(TYPE_MENU, STATE_PRESSED));
        send_request(make_event(TYPE_MENU, STATE_RELEASED));
        send_request(make_event(TYPE_PLAY, STATE_PRESSED));
        send_request(make_event(TYPE_PLAY, STATE_RELEASED));
        send_request(make_event(TYPE_NEXT, STATE_RELEASED));
        send_request(make_frame(ACT_FRAME_END));
        send_request(make_item(ACT_FRAME_BEGIN, 5'b10101, 32'hA5A5_5A5A, CODE_MAX, CODE_MAX));
        send_request(make_frame(ACT_FRAME_END));
        stop_requests();
    endtask

    // Mostly well-formed frames with random events, plus noise and broken frames.
    task automatic test_random_frames(input logic [BUTTON_COUNT-1:0] mask, input int frames);
        int                f;
        int                k;
        int                n;
        logic [CODE_W-1:0] code;
        set_release_mask(mask);
        for (f = 0; f < frames; f++) begin
            if ($urandom_range(0, 9) != 0) begin
                send_request(make_frame(ACT_FRAME_BEGIN));
            end
            n = $urandom_range(0, 8);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(0, 9))
                    0: send_request(random_item());
                    1: begin
                        // A press and release in one frame.
                        code = button_code();
                        send_request(make_event(code, STATE_PRESSED));
                        send_request(make_event(code, STATE_RELEASED));
                    end
                    default: send_request(make_event(pick_type(), pick_state()));
                endcase
            end
            if ($urandom_range(0, 9) != 0) begin
                send_request(make_frame(ACT_FRAME_END));
            end
            // The sender holds off until the pipeline has drained.
            if (f == frames / 2 || $urandom_range(0, 29) == 0) begin
                stop_requests();
                wait_for_results();
            end
        end
        stop_requests();
    endtask

    // Final stretch at full rate on both sides.
    task automatic test_full_rate();
        idling_on = 1'b0;
        test_random_frames(rand_flags(), 30);
    endtask

    // Random result stalls in bursts, started only while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", {27'd0, o_flags_out}, '0);
            end else begin
                want = expected_results.pop_front();
                if (o_flags_out !== want.flags_out) begin
                    report_mismatch("flags_out", {27'd0, o_flags_out}, {27'd0, want.flags_out});
                end
                if (o_hand_back !== want.hand_back) begin
                    report_mismatch("hand_back", {31'd0, o_hand_back}, {31'd0, want.hand_back});
                end
                if (o_next_time !== want.next_time) begin
                    report_mismatch("next_time", o_next_time, want.next_time);
                end
                if (o_menu_time !== want.menu_time) begin
                    report_mismatch("menu_time", o_menu_time, want.menu_time);
                end
            end
        end
    end

    // Ends the run when nothing moves for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[button_event_collector] ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_outside_frame();
        test_directed_frames();
        test_random_frames(BTN_NONE, 35);
        test_random_frames(BTN_ALL, 35);
        test_random_frames(rand_flags(), 35);
        test_random_frames(rand_flags(), 35);
        test_full_rate();
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[button_event_collector] OK");
        end else begin
            $display("[button_event_collector] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/bec_pkg.sv
design/bec_fold.sv
design/button_event_collector.sv
design/bec_checker.sv
verif/button_event_collector_test.sv
